FILE: design/gpio_pkg.sv
// Shared types and constants for the GPIO port with pin interrupts.
// Used by the pin lanes, the merging stage, the response skid buffer and the top level.
`default_nettype none

package gpio_pkg;

   localparam int unsigned PortWidth = 32;
   localparam int unsigned ModeWidth = 4;
   localparam int unsigned PinIdxWidth = 5;

   // Pin control word layout.
   localparam int unsigned ModeLsb = 16;
   localparam int unsigned FlagBit = 24;

   // Interrupt mode codes; other codes are stored but never raise a flag.
   localparam logic [ModeWidth-1:0] MODE_DISABLED   = 4'd0;
   localparam logic [ModeWidth-1:0] MODE_LEVEL_ZERO = 4'd8;
   localparam logic [ModeWidth-1:0] MODE_RISING     = 4'd9;
   localparam logic [ModeWidth-1:0] MODE_FALLING    = 4'd10;
   localparam logic [ModeWidth-1:0] MODE_EITHER     = 4'd11;
   localparam logic [ModeWidth-1:0] MODE_LEVEL_ONE  = 4'd12;

   typedef enum logic [1:0] {
      REQ_IDLE  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      SEL_OUT_DATA = 3'd0,
      SEL_OUT_SET  = 3'd1,
      SEL_OUT_CLR  = 3'd2,
      SEL_IN_DATA  = 3'd3,
      SEL_DIR      = 3'd4,
      SEL_IN_DIS   = 3'd5,
      SEL_PIN_CTL  = 3'd6,
      SEL_FLAGS    = 3'd7
   } reg_sel_type;

   // Control from the top level to one pin lane.
   typedef struct packed {
      logic                 step;       // a request is accepted this cycle
      logic                 cur_level;  // effective input of this pin
      logic                 mode_we;    // pin control write to this pin
      logic [ModeWidth-1:0] mode_wdata;
      logic                 flag_clr;   // write-one-to-clear hit on this pin
   } lane_ctl_type;

   // Status from one pin lane.
   typedef struct packed {
      logic [ModeWidth-1:0] mode;
      logic                 flag;
      logic                 flag_next;
   } lane_sts_type;

   // One response as it is held in the output stage.
   typedef struct packed {
      logic [PortWidth-1:0] rdata;
      logic [PortWidth-1:0] pad_drive;
      logic [PortWidth-1:0] pad_enable;
      logic                 irq;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/gpio_pin_lane.sv
// One pin lane: interrupt mode register, previous level, edge/level detection and flag.
// Depends on gpio_pkg.
`default_nettype none

module gpio_pin_lane (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gpio_pkg::lane_ctl_type ctl,
   output      gpio_pkg::lane_sts_type sts
);
   import gpio_pkg::*;

   logic [ModeWidth-1:0] mode_ff, mode_in;
   logic                 flag_ff, flag_in;
   logic                 prev_ff, prev_in;
   logic                 hit;

   always_comb begin
      case (mode_ff)
         MODE_LEVEL_ZERO: hit = ~ctl.cur_level;
         MODE_RISING:     hit = ctl.cur_level & ~prev_ff;
         MODE_FALLING:    hit = ~ctl.cur_level & prev_ff;
         MODE_EITHER:     hit = ctl.cur_level ^ prev_ff;
         MODE_LEVEL_ONE:  hit = ctl.cur_level;
         default:         hit = 1'b0;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      flag_in = flag_ff;
      prev_in = prev_ff;
      if (ctl.step) begin
         // An event in this cycle wins over a clear in the same cycle.
         flag_in = (flag_ff & ~ctl.flag_clr) | hit;
         prev_in = ctl.cur_level;
         if (ctl.mode_we) begin
            mode_in = ctl.mode_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DISABLED;
         flag_ff <= 1'b0;
         prev_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         flag_ff <= flag_in;
         prev_ff <= prev_in;
      end
   end

   assign sts.mode      = mode_ff;
   assign sts.flag      = flag_ff;
   assign sts.flag_next = flag_in;

endmodule

`default_nettype wire

FILE: design/gpio_merge.sv
// Merging stage: combines the pin lanes into read data and the interrupt line.
// Depends on gpio_pkg.
`default_nettype none

module gpio_merge (
   input  wire gpio_pkg::lane_sts_type             lane_sts [gpio_pkg::PortWidth],
   input  wire logic [1:0]                         req_kind,
   input  wire logic [2:0]                         reg_sel,
   input  wire logic [gpio_pkg::PinIdxWidth-1:0]   pin_index,
   input  wire logic                               pin_ok,
   input  wire logic [gpio_pkg::PortWidth-1:0]     out_value,
   input  wire logic [gpio_pkg::PortWidth-1:0]     eff_levels,
   input  wire logic [gpio_pkg::PortWidth-1:0]     dir_mask,
   input  wire logic [gpio_pkg::PortWidth-1:0]     in_dis_mask,
   output      logic [gpio_pkg::PortWidth-1:0]     rdata,
   output      logic                               irq
);
   import gpio_pkg::*;

   logic [PortWidth-1:0] flags;
   logic [PortWidth-1:0] flags_next;
   logic [PortWidth-1:0] pin_word;

   always_comb begin
      for (int p = 0; p < PortWidth; p++) begin
         flags[p]      = lane_sts[p].flag;
         flags_next[p] = lane_sts[p].flag_next;
      end
   end

   always_comb begin
      pin_word = '0;
      if (pin_ok) begin
         pin_word[ModeLsb +: ModeWidth] = lane_sts[pin_index].mode;
         pin_word[FlagBit]              = lane_sts[pin_index].flag;
      end
   end

   always_comb begin
      rdata = '0;
      if (req_kind_type'(req_kind) == REQ_READ) begin
         case (reg_sel_type'(reg_sel))
            SEL_OUT_DATA: rdata = out_value;
            SEL_IN_DATA:  rdata = eff_levels;
            SEL_DIR:      rdata = dir_mask;
            SEL_IN_DIS:   rdata = in_dis_mask;
            SEL_PIN_CTL:  rdata = pin_word;
            SEL_FLAGS:    rdata = flags;
            default:      rdata = '0;
         endcase
      end
   end

   assign irq = |flags_next;

endmodule

`default_nettype wire

FILE: design/gpio_rsp_skid.sv
// Output register plus one skid entry for the response channel.
// Depends on gpio_pkg.
`default_nettype none

module gpio_rsp_skid (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire gpio_pkg::rsp_type in_data,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output      gpio_pkg::rsp_type out_data
);
   import gpio_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    take;
   logic    put;

   assign in_ready = ~skid_valid_ff;
   assign take     = out_valid_ff & out_ready;
   assign put      = in_valid & ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (put) begin
         if (!out_valid_ff || take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // The skid entry only fills behind a waiting output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without output register valid");

   // A request arriving while the output stalls lands in the skid entry.
   a_skid_fills: assert property (@(posedge clock) disable iff (reset)
      (put && out_valid_ff && !out_ready) |=> skid_valid_ff)
      else $error("stalled request was not captured in the skid entry");

   // Nothing is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !skid_valid_ff))
      else $error("response stage not empty after reset");

endmodule

`default_nettype wire

FILE: design/gpio_port_with_pin_interrupts_core.sv
// Top level of the GPIO port with per-pin interrupt detection.
// Depends on gpio_pkg, gpio_pin_lane, gpio_merge and gpio_rsp_skid.
//
//   Channel  Handshake                 Payload
//   req      req_valid / req_ready     req_type, req_reg_sel, req_pin_index,
//                                      req_wdata, req_pad_levels
//   rsp      rsp_valid / rsp_ready     rsp_rdata, rsp_pad_drive, rsp_pad_enable, rsp_irq
//
// Each request is processed in the cycle it is accepted: the port registers and every
// pin lane update at that edge, and its response is registered in the output register,
// or in the skid entry while a response waits there. One request per cycle is sustained
// while req_ready stays high. A one-entry skid stage keeps requests flowing while a
// response waits, so req_ready drops only when both output entries are full.
// Reset is synchronous and clears all port registers, modes, flags and previous levels.
`default_nettype none

module gpio_port_with_pin_interrupts_core #(
   parameter int unsigned PIN_COUNT = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [2:0]  req_reg_sel,
   input  wire logic [4:0]  req_pin_index,
   input  wire logic [31:0] req_wdata,
   input  wire logic [31:0] req_pad_levels,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [31:0] rsp_rdata,
   output      logic [31:0] rsp_pad_drive,
   output      logic [31:0] rsp_pad_enable,
   output      logic        rsp_irq
);
   import gpio_pkg::*;

   // Bits of pins that exist; everything above reads and acts as zero.
   localparam logic [PortWidth-1:0] PinMask = PortWidth'((64'd1 << PIN_COUNT) - 64'd1);

   logic [PortWidth-1:0] out_value_ff, out_value_in;
   logic [PortWidth-1:0] dir_mask_ff, dir_mask_in;
   logic [PortWidth-1:0] in_dis_ff, in_dis_in;

   logic                 accept;
   logic                 is_write;
   logic                 pin_ok;
   logic [PortWidth-1:0] eff_levels;
   logic [PortWidth-1:0] flag_clr;
   logic [PortWidth-1:0] rdata;
   logic                 irq;
   lane_ctl_type         lane_ctl [PortWidth];
   lane_sts_type         lane_sts [PortWidth];
   rsp_type              rsp_new;
   rsp_type              rsp_out;

   assign accept     = req_valid & req_ready;
   assign is_write   = (req_kind_type'(req_type) == REQ_WRITE);
   assign pin_ok     = ({1'b0, req_pin_index} < 6'(PIN_COUNT));
   assign eff_levels = req_pad_levels & ~in_dis_ff & PinMask;

   // Write-one-to-clear flags, either the whole flag register or one pin control word.
   always_comb begin
      flag_clr = '0;
      if (is_write) begin
         if (reg_sel_type'(req_reg_sel) == SEL_FLAGS) begin
            flag_clr = req_wdata;
         end else if ((reg_sel_type'(req_reg_sel) == SEL_PIN_CTL) && pin_ok) begin
            flag_clr[req_pin_index] = req_wdata[FlagBit];
         end
      end
   end

   // Port-wide registers.
   always_comb begin
      out_value_in = out_value_ff;
      dir_mask_in  = dir_mask_ff;
      in_dis_in    = in_dis_ff;
      if (accept && is_write) begin
         case (reg_sel_type'(req_reg_sel))
            SEL_OUT_DATA: out_value_in = req_wdata & PinMask;
            SEL_OUT_SET:  out_value_in = (out_value_ff | req_wdata) & PinMask;
            SEL_OUT_CLR:  out_value_in = out_value_ff & ~req_wdata;
            SEL_DIR:      dir_mask_in  = req_wdata & PinMask;
            SEL_IN_DIS:   in_dis_in    = req_wdata & PinMask;
            default:      out_value_in = out_value_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_value_ff <= '0;
         dir_mask_ff  <= '0;
         in_dis_ff    <= '0;
      end else begin
         out_value_ff <= out_value_in;
         dir_mask_ff  <= dir_mask_in;
         in_dis_ff    <= in_dis_in;
      end
   end

   // One lane per existing pin; lanes for absent pins are tied off to zero.
   for (genvar p = 0; p < PortWidth; p++) begin : g_lane
      if (p < PIN_COUNT) begin : g_pin
         always_comb begin
            lane_ctl[p].step       = accept;
            lane_ctl[p].cur_level  = eff_levels[p];
            lane_ctl[p].mode_we    = is_write && pin_ok &&
                                     (reg_sel_type'(req_reg_sel) == SEL_PIN_CTL) &&
                                     (req_pin_index == PinIdxWidth'(p));
            lane_ctl[p].mode_wdata = req_wdata[ModeLsb +: ModeWidth];
            lane_ctl[p].flag_clr   = flag_clr[p];
         end

         gpio_pin_lane u_lane (
            .clock (clock),
            .reset (reset),
            .ctl   (lane_ctl[p]),
            .sts   (lane_sts[p])
         );
      end else begin : g_absent
         assign lane_ctl[p] = '0;
         assign lane_sts[p] = '0;
      end
   end

   gpio_merge u_merge (
      .lane_sts    (lane_sts),
      .req_kind    (req_type),
      .reg_sel     (req_reg_sel),
      .pin_index   (req_pin_index),
      .pin_ok      (pin_ok),
      .out_value   (out_value_ff),
      .eff_levels  (eff_levels),
      .dir_mask    (dir_mask_ff),
      .in_dis_mask (in_dis_ff),
      .rdata       (rdata),
      .irq         (irq)
   );

   // The response carries the read data and the port state after this request.
   always_comb begin
      rsp_new.rdata      = rdata;
      rsp_new.pad_drive  = out_value_in;
      rsp_new.pad_enable = dir_mask_in;
      rsp_new.irq        = irq;
   end

   gpio_rsp_skid u_rsp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (rsp_new),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_out)
   );

   assign rsp_rdata      = rsp_out.rdata;
   assign rsp_pad_drive  = rsp_out.pad_drive;
   assign rsp_pad_enable = rsp_out.pad_enable;
   assign rsp_irq        = rsp_out.irq;

   // Drive and enable never show pins that do not exist.
   a_drive_masked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_pad_drive | rsp_pad_enable) & ~PinMask) == '0))
      else $error("pad drive or enable set on an absent pin");

   // A write to the read-only input data register changes no port register.
   a_in_data_ro: assert property (@(posedge clock) disable iff (reset)
      (accept && is_write && (reg_sel_type'(req_reg_sel) == SEL_IN_DATA)) |=>
      ($stable(out_value_ff) && $stable(dir_mask_ff) && $stable(in_dis_ff)))
      else $error("write to input data changed a port register");

   // Port registers only move when a request is accepted.
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(out_value_ff) && $stable(dir_mask_ff) && $stable(in_dis_ff)))
      else $error("port register changed without an accepted request");

endmodule

`default_nettype wire

FILE: bench/tb_gpio_port_with_pin_interrupts_core.sv
// Self-checking testbench for the GPIO port with per-pin interrupt detection.
// Depends on gpio_pkg and on gpio_port_with_pin_interrupts_core with its submodules;
// it predicts every response in place and compares it with what the port returns.
`default_nettype none

module tb_gpio_port_with_pin_interrupts_core;
   timeunit 1ns;
   timeprecision 1ps;

   import gpio_pkg::*;

   localparam int unsigned PinCount = 32;
   // Generous bound on the whole run, several times the slowest legal run.
   localparam int unsigned CycleLimit = 300000;
   // Cap on printed mismatch lines; every mismatch is still counted.
   localparam int unsigned PrintCap = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = REQ_IDLE;
   logic [2:0]  req_reg_sel = SEL_OUT_DATA;
   logic [4:0]  req_pin_index = '0;
   logic [31:0] req_wdata = '0;
   logic [31:0] req_pad_levels = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_rdata;
   logic [31:0] rsp_pad_drive;
   logic [31:0] rsp_pad_enable;
   logic        rsp_irq;

   gpio_port_with_pin_interrupts_core #(
      .PIN_COUNT(PinCount)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_reg_sel   (req_reg_sel),
      .req_pin_index (req_pin_index),
      .req_wdata     (req_wdata),
      .req_pad_levels(req_pad_levels),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rdata     (rsp_rdata),
      .rsp_pad_drive (rsp_pad_drive),
      .rsp_pad_enable(rsp_pad_enable),
      .rsp_irq       (rsp_irq)
   );

   // 4 ns clock period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predicted port state. It advances once per accepted request, exactly
   // as the port registers do, so it always describes the port as it will
   // look after the most recently accepted request.
   // ------------------------------------------------------------------
   logic [31:0]          port_out;
   logic [31:0]          port_dir;
   logic [31:0]          port_in_dis;
   logic [ModeWidth-1:0] pin_mode [PortWidth];
   logic [31:0]          pin_flags;
   logic [31:0]          last_eff_levels;

   // Responses predicted for accepted requests, oldest first.
   rsp_type port_view_q[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   // When clear, neither the sender nor the receiver inserts idle cycles.
   bit          idle_on = 1'b1;
   // Pad levels carried from one random request to the next so that most
   // pins change slowly and edge modes see clean transitions.
   logic [31:0] pads_now = '0;

   function automatic logic [31:0] pin_mask();
      return (PinCount >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PinCount) - 32'd1);
   endfunction

   function automatic void clear_port_model();
      port_out = '0;
      port_dir = '0;
      port_in_dis = '0;
      pin_flags = '0;
      last_eff_levels = '0;
      for (int p = 0; p < PortWidth; p++) pin_mode[p] = MODE_DISABLED;
   endfunction

   // Computes the response to one request and advances the predicted state.
   // Reads show the registers from before the request; the input data read
   // shows this cycle's effective input. Interrupt events are judged with the
   // modes in force before the request, and an event wins over a clear that
   // lands in the same cycle.
   function automatic rsp_type predict_port_access(input logic [1:0]  kind,
                                                   input logic [2:0]  sel,
                                                   input logic [4:0]  pin,
                                                   input logic [31:0] wd,
                                                   input logic [31:0] pads);
      logic [31:0] mask;
      logic [31:0] eff;
      logic [31:0] rd;
      logic [31:0] clr;
      logic [31:0] events;
      logic        hit;
      logic        pin_ok;
      rsp_type     view;

      mask = pin_mask();
      eff = pads & ~port_in_dis & mask;
      pin_ok = (pin < PinCount);
      rd = '0;
      clr = '0;
      events = '0;

      if (kind == REQ_READ) begin
         case (sel)
            SEL_OUT_DATA: rd = port_out;
            SEL_IN_DATA:  rd = eff;
            SEL_DIR:      rd = port_dir;
            SEL_IN_DIS:   rd = port_in_dis;
            SEL_PIN_CTL: begin
               if (pin_ok) begin
                  rd[ModeLsb +: ModeWidth] = pin_mode[pin];
                  rd[FlagBit] = pin_flags[pin];
               end
            end
            SEL_FLAGS:    rd = pin_flags;
            default:      rd = '0;
         endcase
      end

      for (int p = 0; p < PortWidth; p++) begin
         case (pin_mode[p])
            MODE_LEVEL_ZERO: hit = !eff[p];
            MODE_RISING:     hit = eff[p] && !last_eff_levels[p];
            MODE_FALLING:    hit = !eff[p] && last_eff_levels[p];
            MODE_EITHER:     hit = eff[p] != last_eff_levels[p];
            MODE_LEVEL_ONE:  hit = eff[p];
            default:         hit = 1'b0;
         endcase
         events[p] = hit;
      end
      events &= mask;

      if (kind == REQ_WRITE) begin
         case (sel)
            SEL_OUT_DATA: port_out = wd & mask;
            SEL_OUT_SET:  port_out = (port_out | wd) & mask;
            SEL_OUT_CLR:  port_out = port_out & ~wd;
            SEL_DIR:      port_dir = wd & mask;
            SEL_IN_DIS:   port_in_dis = wd & mask;
            SEL_PIN_CTL: begin
               if (pin_ok) begin
                  pin_mode[pin] = wd[ModeLsb +: ModeWidth];
                  if (wd[FlagBit]) clr[pin] = 1'b1;
               end
            end
            SEL_FLAGS:    clr = wd;
            default:      ;   // input data is read-only
         endcase
      end

      pin_flags = ((pin_flags & ~clr) | events) & mask;
      last_eff_levels = eff;

      view.rdata = rd;
      view.pad_drive = port_out;
      view.pad_enable = port_dir;
      view.irq = (pin_flags != '0);
      return view;
   endfunction

   // Builds a pin control word from a mode and the flag clear bit.
   function automatic logic [31:0] pin_ctl_word(input logic [ModeWidth-1:0] mode,
                                                input logic clear_flag);
      logic [31:0] word;
      word = '0;
      word[ModeLsb +: ModeWidth] = mode;
      word[FlagBit] = clear_flag;
      return word;
   endfunction

   // ------------------------------------------------------------------
   // Mismatch reporting and response checking.
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PrintCap)
         $display("[%0t] MISMATCH %s: got %08h, want %08h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Each response taken by the receiver is compared with the oldest
   // prediction. Sampling happens in the active region right after the
   // edge, so all values seen are the ones that were stable at the edge.
   rsp_type want_view;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (port_view_q.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_rdata, '0);
         end else begin
            want_view = port_view_q.pop_front();
            if (rsp_rdata !== want_view.rdata)
               report_mismatch("rdata", rsp_rdata, want_view.rdata);
            if (rsp_pad_drive !== want_view.pad_drive)
               report_mismatch("pad_drive", rsp_pad_drive, want_view.pad_drive);
            if (rsp_pad_enable !== want_view.pad_enable)
               report_mismatch("pad_enable", rsp_pad_enable, want_view.pad_enable);
            if (rsp_irq !== want_view.irq)
               report_mismatch("irq", {31'd0, rsp_irq}, {31'd0, want_view.irq});
         end
      end
   end

   // Receiver back-pressure: random stalls while idling is enabled, ready held
   // high otherwise.
   int unsigned stall_left = 0;

   always @(posedge clock) begin
      if (idle_on && stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request driver. It is entered and left at a rising edge. Valid stays
   // high from one request to the next unless a random gap is inserted, so
   // there is never more than one assignment to valid in a time step.
   // ------------------------------------------------------------------
   task automatic send_request(input logic [1:0]  kind,
                               input logic [2:0]  sel,
                               input logic [4:0]  pin,
                               input logic [31:0] wd,
                               input logic [31:0] pads);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_reg_sel <= sel;
      req_pin_index <= pin;
      req_wdata <= wd;
      req_pad_levels <= pads;
      // Accepted at the first edge where ready was high with valid.
      do @(posedge clock); while (!req_ready);
      port_view_q.push_back(predict_port_access(kind, sel, pin, wd, pads));
   endtask

   // Stops the sender and waits until every predicted response has arrived.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (port_view_q.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Directed tests.
   // ------------------------------------------------------------------

   // Output data with its write, set and clear aliases, direction, the
   // write-only aliases reading zero and the read-only input data register
   // ignoring writes. The very first request after reset carries all pads
   // high, so every pin looks like a rising edge, but no mode is armed yet.
   task automatic test_output_registers();
      send_request(REQ_READ,  SEL_IN_DATA,  5'd0,  32'h0000_0000, 32'hFFFF_FFFF);
      send_request(REQ_WRITE, SEL_OUT_DATA, 5'd0,  32'hFFFF_FFFF, 32'h0000_0000);
      send_request(REQ_WRITE, SEL_OUT_CLR,  5'd0,  32'h0000_FFFF, 32'h0000_0000);
      send_request(REQ_WRITE, SEL_OUT_SET,  5'd0,  32'h0000_0001, 32'h0000_0000);
      send_request(REQ_READ,  SEL_OUT_DATA, 5'd31, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(REQ_READ,  SEL_OUT_SET,  5'd0,  32'h0000_0000, 32'h0000_0000);
      send_request(REQ_READ,  SEL_OUT_CLR,  5'd0,  32'h0000_0000, 32'h0000_0000);
      send_request(REQ_WRITE, SEL_IN_DATA,  5'd0,  32'hFFFF_FFFF, 32'h0000_0000);
      send_request(REQ_WRITE, SEL_DIR,      5'd0,  32'hFFFF_FFFF, 32'h0000_0000);
      send_request(REQ_READ,  SEL_DIR,      5'd0,  32'h0000_0000, 32'h0000_0000);
   endtask

   // Input disable masks the input data read; the mask is read back and then cleared.
   task automatic test_input_path();
      send_request(REQ_WRITE, SEL_IN_DIS,  5'd0, 32'hAAAA_AAAA, 32'h0000_0000);
      send_request(REQ_READ,  SEL_IN_DIS,  5'd0, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(REQ_READ,  SEL_IN_DATA, 5'd0, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(REQ_WRITE, SEL_IN_DIS,  5'd0, 32'h0000_0000, 32'h0000_0000);
   endtask

   // Every interrupt mode plus an unsupported code, reads of pin control
   // and flags, clearing through the flags register and through the pin
   // control word, a clear colliding with a new event, and request type 3.
   task automatic test_pin_interrupts();
      send_request(REQ_WRITE, SEL_PIN_CTL, 5'd0,  pin_ctl_word(MODE_LEVEL_ZERO, 1'b0), '0);
      send_request(REQ_WRITE, SEL_PIN_CTL, 5'd1,  pin_ctl_word(MODE_RISING, 1'b0), '0);
      send_request(REQ_WRITE, SEL_PIN_CTL, 5'd2,  pin_ctl_word(MODE_FALLING, 1'b0), '0);
      send_request(REQ_WRITE, SEL_PIN_CTL, 5'd3,  pin_ctl_word(MODE_EITHER, 1'b0), '0);
      send_request(REQ_WRITE, SEL_PIN_CTL, 5'd31, pin_ctl_word(MODE_LEVEL_ONE, 1'b0), '0);
      send_request(REQ_WRITE, SEL_PIN_CTL, 5'd4,  pin_ctl_word(4'hF, 1'b0), '0);
      send_request(REQ_READ,  SEL_FLAGS,   5'd0,  '0, 32'h8000_001E);
      send_request(REQ_READ,  SEL_PIN_CTL, 5'd31, '0, 32'h0000_0004);
      // Level-one on pin 31 fires in the same cycle the flags are cleared.
      send_request(REQ_WRITE, SEL_FLAGS,   5'd0,  32'hFFFF_FFFF, 32'h8000_001F);
      send_request(REQ_WRITE, SEL_PIN_CTL, 5'd31, pin_ctl_word(MODE_DISABLED, 1'b1), '0);
      send_request(REQ_READ,  SEL_PIN_CTL, 5'd2,  '0, 32'h0000_0004);
      send_request(2'd3,      SEL_FLAGS,   5'd7,  32'hFFFF_FFFF, 32'h0000_0000);
      send_request(REQ_READ,  SEL_PIN_CTL, 5'd4,  '0, 32'h0000_0000);
   endtask

   // ------------------------------------------------------------------
   // Random accesses. Most requests are well-formed register traffic with
   // legal mode codes so that every interrupt mode stays armed on some pins;
   // the rest use arbitrary control words. Pads mostly flip a few bits per
   // request, with an occasional fully random pattern.
   // ------------------------------------------------------------------
   task automatic test_random_accesses(input int unsigned count, input bit allow_idle);
      logic [1:0]           kind;
      logic [2:0]           sel;
      logic [31:0]          wd;
      logic [ModeWidth-1:0] mode;
      int unsigned          pick;

      for (int unsigned n = 0; n < count; n++) begin
         // Idle stretches come and go in blocks so that quiet runs occur too.
         if (n % 100 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);

         pick = $urandom_range(0, 9);
         kind = (pick < 2) ? REQ_IDLE : (pick < 5) ? REQ_READ : REQ_WRITE;
         if ($urandom_range(0, 99) == 0) kind = 2'd3;
         sel = 3'($urandom_range(0, 7));
         wd = $urandom();

         if (sel == SEL_PIN_CTL && $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0:       mode = MODE_DISABLED;
               1:       mode = MODE_LEVEL_ZERO;
               2:       mode = MODE_RISING;
               3:       mode = MODE_FALLING;
               4:       mode = MODE_EITHER;
               default: mode = MODE_LEVEL_ONE;
            endcase
            wd = pin_ctl_word(mode, 1'($urandom_range(0, 1)));
         end else if (sel == SEL_FLAGS && $urandom_range(0, 1) == 0) begin
            // Targeted clears leave most flags standing.
            wd = $urandom() & $urandom() & $urandom();
         end else if (sel == SEL_IN_DIS && $urandom_range(0, 2) != 0) begin
            wd = $urandom() & $urandom();
         end

         if ($urandom_range(0, 9) == 0) pads_now = $urandom();
         else pads_now ^= $urandom() & $urandom() & $urandom();

         send_request(kind, sel, 5'($urandom_range(0, 31)), wd, pads_now);
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      clear_port_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_output_registers();
      test_input_path();
      test_pin_interrupts();
      // The sender holds off here until the port has returned everything.
      drain_responses();
      test_random_accesses(1000, 1'b1);
      drain_responses();
      // Final stretch runs at full rate with no idling on either side.
      idle_on = 1'b0;
      test_random_accesses(150, 1'b0);
      drain_responses();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: gpio_port_with_pin_interrupts_core.f
design/gpio_pkg.sv
design/gpio_pin_lane.sv
design/gpio_merge.sv
design/gpio_rsp_skid.sv
design/gpio_port_with_pin_interrupts_core.sv
bench/tb_gpio_port_with_pin_interrupts_core.sv
